[src/convex_fan_vertex_setup_unit_macros.svh]
// Assertion macros shared by the fan setup RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CONVEX_FAN_VERTEX_SETUP_UNIT_MACROS_SVH
`define CONVEX_FAN_VERTEX_SETUP_UNIT_MACROS_SVH

// Same-cycle implication.
`define CFVS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfvs: implication check failed");

// Next-cycle implication.
`define CFVS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfvs: next-cycle check failed");

`endif

[src/cfvs_pkg.sv]
// Package for the convex fan vertex setup unit: constants, payload and job types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfvs_pkg;

  localparam int MAX_POINTS = 62;
  localparam int IDX_W      = 6;
  localparam int COORD_W    = 16;
  localparam int TEX_W      = 17;
  localparam int FRAC_STEPS = 16;
  localparam logic [IDX_W-1:0] MIN_FAN_POINTS = 6'd3;
  localparam logic [IDX_W-1:0] MAX_POINTS_V   = 6'(MAX_POINTS);
  localparam logic [TEX_W-1:0] ONE_Q4         = 17'd16;
  localparam logic [TEX_W-1:0] TEX_ONE        = 17'h10000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic        [IDX_W-1:0]   point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } item_t;

  typedef struct packed {
    logic        [IDX_W-1:0]   vertex_slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic        [TEX_W-1:0]   tex_u;
    logic        [TEX_W-1:0]   tex_v;
    logic                      last_of_run;
  } vertex_t;

  typedef struct packed {
    logic [IDX_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_SETUP,
    S_FETCH,
    S_LOAD,
    S_DIV,
    S_OUT
  } back_state_t;

endpackage

`default_nettype wire

[src/convex_fan_vertex_setup_unit.sv]
// Top level of the convex fan vertex setup unit.
// Depends on cfvs_pkg, cfvs_front, cfvs_queue and cfvs_back.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on start/item writes one polygon point into the 62-entry
// store (an index of 62 or more writes nothing) and, when the point count is at
// least three (values above 62 act as 62), produces a triangle fan of n+2
// vertices: slot 0 is the bounding-box centre, slots 1..n the stored points,
// slot n+1 the first point again. Each vertex appears on the vertex port for
// exactly one cycle with vertex_strobe high; the receiver cannot stall, so it
// must take every strobe. busy stays high from the cycle after an accepted
// item until its last vertex has gone out; an item that yields no fan leaves
// busy low. Per item, with n points in use, the back end takes the job from
// the queue, scans the bounds (one store read and one compare per point), runs
// a setup step, then for each vertex fetches its point (the centre needs no
// fetch), loads it and runs the 16-step bit-serial divider that forms both
// texture coordinates. The store reads as zero after reset (per-entry valid
// bits, no clearing pass). The point count is written through
// cfg_valid/cfg_ready, which is always ready; write it only while idle.
module convex_fan_vertex_setup_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  cfvs_pkg::item_t            item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cfvs_pkg::IDX_W-1:0] cfg_data,
  output logic                       vertex_strobe,
  output cfvs_pkg::vertex_t          vertex
);

  logic                       accept;
  logic                       job_push;
  logic                       job_valid;
  logic                       job_pop;
  logic                       back_active;
  cfvs_pkg::job_t             push_job;
  cfvs_pkg::job_t             head_job;
  cfvs_pkg::queue_ctl_t       q_ctl;
  logic [cfvs_pkg::IDX_W-1:0] rd_addr;
  cfvs_pkg::point_t           rd_point;

  // one item in flight at a time: the back end reads the store the front writes
  assign busy      = job_valid || back_active;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign q_ctl.push = job_push;
  assign q_ctl.pop  = job_pop;

  cfvs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .rd_addr  (rd_addr),
    .rd_point (rd_point),
    .job_push (job_push),
    .job      (push_job)
  );

  cfvs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (q_ctl),
    .wr_job    (push_job),
    .not_empty (job_valid),
    .rd_job    (head_job)
  );

  cfvs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job           (head_job),
    .job_pop       (job_pop),
    .rd_addr       (rd_addr),
    .rd_point      (rd_point),
    .active        (back_active),
    .vertex_strobe (vertex_strobe),
    .vertex        (vertex)
  );

endmodule

`default_nettype wire

[src/cfvs_front.sv]
// Front end: count register, point store with valid bits, job classification.
// Depends on cfvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfvs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  cfvs_pkg::item_t               item,
  input  logic                          cfg_we,
  input  logic [cfvs_pkg::IDX_W-1:0]    cfg_data,
  input  logic [cfvs_pkg::IDX_W-1:0]    rd_addr,
  output cfvs_pkg::point_t              rd_point,
  output logic                          job_push,
  output cfvs_pkg::job_t                job
);

  logic [cfvs_pkg::IDX_W-1:0]      fan_size;
  logic [cfvs_pkg::MAX_POINTS-1:0] valid;
  cfvs_pkg::point_t                mem [cfvs_pkg::MAX_POINTS];
  cfvs_pkg::point_t                rd_q;
  logic                            rd_ok;
  logic                            wr_en;
  logic [cfvs_pkg::IDX_W-1:0]      n_clamp;

  assign wr_en = accept && (item.point_index < cfvs_pkg::MAX_POINTS_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_size <= '0;
    end else if (cfg_we) begin
      fan_size <= cfg_data;
    end
  end

  // valid bits stand in for the all-zero reset of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[item.point_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[item.point_index] <= '{x: item.point_x, y: item.point_y};
    end
  end

  always_ff @(posedge clk) begin
    rd_q  <= mem[rd_addr];
    rd_ok <= valid[rd_addr];
  end

  assign rd_point = rd_ok ? rd_q : '0;

  assign n_clamp   = (fan_size > cfvs_pkg::MAX_POINTS_V) ? cfvs_pkg::MAX_POINTS_V
                                                       : fan_size;
  assign job_push  = accept && (n_clamp >= cfvs_pkg::MIN_FAN_POINTS);
  assign job.count = n_clamp;

endmodule

`default_nettype wire

[src/cfvs_queue.sv]
// Two-entry job queue between front and back.
// Depends on cfvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfvs_queue (
  input  logic                clk,
  input  logic                rst,
  input  cfvs_pkg::queue_ctl_t ctl,
  input  cfvs_pkg::job_t      wr_job,
  output logic                not_empty,
  output cfvs_pkg::job_t      rd_job
);

  cfvs_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign do_push   = ctl.push && (fill != 2'd2);
  assign do_pop    = ctl.pop && (fill != 2'd0);
  assign not_empty = (fill != 2'd0);
  assign rd_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

[src/cfvs_back.sv]
// Back end: bounds scan, centre and span setup, per-vertex texture division, emit.
// Depends on cfvs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "convex_fan_vertex_setup_unit_macros.svh"

module cfvs_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  cfvs_pkg::job_t             job,
  output logic                       job_pop,
  output logic [cfvs_pkg::IDX_W-1:0] rd_addr,
  input  cfvs_pkg::point_t           rd_point,
  output logic                       active,
  output logic                       vertex_strobe,
  output cfvs_pkg::vertex_t          vertex
);

  cfvs_pkg::back_state_t state, state_next;

  logic [cfvs_pkg::IDX_W-1:0]          n;
  logic [cfvs_pkg::IDX_W-1:0]          idx;
  logic [cfvs_pkg::IDX_W-1:0]          slot;
  logic signed [cfvs_pkg::COORD_W-1:0] min_x, min_y, max_x, max_y;
  logic signed [cfvs_pkg::COORD_W-1:0] cen_x, cen_y, cur_x, cur_y;
  logic [cfvs_pkg::TEX_W-1:0]          span_x, span_y;
  logic [cfvs_pkg::TEX_W-1:0]          rem_u, rem_v, q_u, q_v;
  logic [3:0]                          step;

  logic                                is_last;
  cfvs_pkg::point_t                    src;
  logic [cfvs_pkg::TEX_W-1:0]          dx, dy, sx, sy, r2u, r2v;
  logic [cfvs_pkg::TEX_W-1:0]          sum_x, sum_y;
  logic                                bu, bv;

  assign is_last = (slot == n + 6'd1);
  assign src     = (slot == '0) ? cfvs_pkg::point_t'{x: cen_x, y: cen_y} : rd_point;

  always_comb begin
    dx    = {src.x[15], src.x} - {min_x[15], min_x};
    dy    = {src.y[15], src.y} - {min_y[15], min_y};
    sx    = {max_x[15], max_x} - {min_x[15], min_x};
    sy    = {max_y[15], max_y} - {min_y[15], min_y};
    sum_x = {max_x[15], max_x} + {min_x[15], min_x};
    sum_y = {max_y[15], max_y} + {min_y[15], min_y};
    r2u   = {rem_u[15:0], 1'b0};
    r2v   = {rem_v[15:0], 1'b0};
    bu    = (r2u >= span_x);
    bv    = (r2v >= span_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfvs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    job_pop       = 1'b0;
    rd_addr       = idx;
    vertex_strobe = 1'b0;
    case (state)
      cfvs_pkg::S_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = cfvs_pkg::S_SCAN_RD;
        end
      end
      cfvs_pkg::S_SCAN_RD:  state_next = cfvs_pkg::S_SCAN_ACC;
      cfvs_pkg::S_SCAN_ACC: begin
        state_next = (idx == n - 6'd1) ? cfvs_pkg::S_SETUP : cfvs_pkg::S_SCAN_RD;
      end
      cfvs_pkg::S_SETUP: state_next = cfvs_pkg::S_LOAD;
      cfvs_pkg::S_FETCH: begin
        rd_addr    = is_last ? '0 : slot - 6'd1;
        state_next = cfvs_pkg::S_LOAD;
      end
      cfvs_pkg::S_LOAD: state_next = cfvs_pkg::S_DIV;
      cfvs_pkg::S_DIV: begin
        if (step == 4'(cfvs_pkg::FRAC_STEPS - 1)) state_next = cfvs_pkg::S_OUT;
      end
      cfvs_pkg::S_OUT: begin
        vertex_strobe = 1'b1;
        state_next    = is_last ? cfvs_pkg::S_IDLE : cfvs_pkg::S_FETCH;
      end
      default: state_next = cfvs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      cfvs_pkg::S_IDLE: begin
        n   <= job.count;
        idx <= '0;
      end
      cfvs_pkg::S_SCAN_ACC: begin
        if (idx == '0 || rd_point.x < min_x) min_x <= rd_point.x;
        if (idx == '0 || rd_point.y < min_y) min_y <= rd_point.y;
        if (idx == '0 || rd_point.x > max_x) max_x <= rd_point.x;
        if (idx == '0 || rd_point.y > max_y) max_y <= rd_point.y;
        idx <= idx + 6'd1;
      end
      cfvs_pkg::S_SETUP: begin
        span_x <= (sx == '0) ? cfvs_pkg::ONE_Q4 : sx;
        span_y <= (sy == '0) ? cfvs_pkg::ONE_Q4 : sy;
        // arithmetic shift of the 17-bit sum gives floor((min+max)/2)
        cen_x  <= sum_x[16:1];
        cen_y  <= sum_y[16:1];
        slot   <= '0;
      end
      cfvs_pkg::S_LOAD: begin
        // offset never exceeds span, so the integer quotient bit is 0 or 1
        cur_x <= src.x;
        cur_y <= src.y;
        q_u   <= {16'd0, dx >= span_x};
        q_v   <= {16'd0, dy >= span_y};
        rem_u <= (dx >= span_x) ? dx - span_x : dx;
        rem_v <= (dy >= span_y) ? dy - span_y : dy;
        step  <= '0;
      end
      cfvs_pkg::S_DIV: begin
        q_u   <= {q_u[15:0], bu};
        q_v   <= {q_v[15:0], bv};
        rem_u <= bu ? r2u - span_x : r2u;
        rem_v <= bv ? r2v - span_y : r2v;
        step  <= step + 4'd1;
      end
      cfvs_pkg::S_OUT: begin
        slot <= slot + 6'd1;
      end
      default: begin
      end
    endcase
  end

  assign active             = (state != cfvs_pkg::S_IDLE);
  assign vertex.vertex_slot = slot;
  assign vertex.pos_x       = cur_x;
  assign vertex.pos_y       = cur_y;
  assign vertex.tex_u       = q_u;
  assign vertex.tex_v       = q_v;
  assign vertex.last_of_run = is_last;

  `CFVS_ASSERT_NXT(a_last_ends_fan, clk, rst, vertex_strobe && vertex.last_of_run,
                   state == cfvs_pkg::S_IDLE)
  `CFVS_ASSERT_IMP(a_tex_in_range, clk, rst, vertex_strobe,
                   vertex.tex_u <= cfvs_pkg::TEX_ONE && vertex.tex_v <= cfvs_pkg::TEX_ONE)
  `CFVS_ASSERT_IMP(a_bounds_ordered, clk, rst, state == cfvs_pkg::S_SETUP,
                   min_x <= max_x && min_y <= max_y)
  `CFVS_ASSERT_IMP(a_job_big_enough, clk, rst, job_pop,
                   job.count >= cfvs_pkg::MIN_FAN_POINTS)

endmodule

`default_nettype wire

[tb/tb_convex_fan_vertex_setup_unit.sv]
// Self-checking testbench for the convex fan vertex setup unit.
// Depends on cfvs_pkg and convex_fan_vertex_setup_unit; predicts each fan in-line.
`timescale 1ns / 1ps
`default_nettype none

module tb_convex_fan_vertex_setup_unit;
  import cfvs_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [IDX_W-1:0] cfg_data;
  logic        vertex_strobe;
  vertex_t     vertex;

  convex_fan_vertex_setup_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .vertex_strobe(vertex_strobe), .vertex(vertex)
  );

  // Shadow copy of the point store and the count register.
  int          shadow_x [MAX_POINTS];
  int          shadow_y [MAX_POINTS];
  int          fan_count;
  vertex_t     fan_queue[$];
  int          mismatches;
  int          idle_cycles;
  bit          timed_out;
  bit          calm;       // no idling while set

  // Directed rows: item plus an optional hand-written first vertex.
  typedef struct {
    item_t   it;
    bit      has_hand;
    vertex_t hand;
  } row_t;
  row_t        rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TEX_W-1:0] tex_of(int p, int lo, int span);
    longint num;
    num = longint'(p - lo) << 16;
    return TEX_W'(num / span);
  endfunction

  function automatic int floor_half(int s);
    if (s >= 0) return s / 2;
    return -((-s + 1) / 2);
  endfunction

  function automatic vertex_t make_vertex(int slot, int x, int y, int mnx, int mny,
                                          int spx, int spy, bit last);
    vertex_t v;
    v.vertex_slot = IDX_W'(slot);
    v.pos_x       = COORD_W'(x);
    v.pos_y       = COORD_W'(y);
    v.tex_u       = tex_of(x, mnx, spx);
    v.tex_v       = tex_of(y, mny, spy);
    v.last_of_run = last;
    return v;
  endfunction

  // Store the point and queue the expected fan.
  task automatic predict_fan(item_t it);
    int n, mnx, mny, mxx, mxy, spx, spy;
    if (it.point_index < MAX_POINTS) begin
      shadow_x[it.point_index] = it.point_x;
      shadow_y[it.point_index] = it.point_y;
    end
    n = (fan_count > MAX_POINTS) ? MAX_POINTS : fan_count;
    if (n < MIN_FAN_POINTS) return;
    mnx = shadow_x[0]; mxx = mnx;
    mny = shadow_y[0]; mxy = mny;
    for (int i = 1; i < n; i++) begin
      if (shadow_x[i] < mnx) mnx = shadow_x[i];
      if (shadow_x[i] > mxx) mxx = shadow_x[i];
      if (shadow_y[i] < mny) mny = shadow_y[i];
      if (shadow_y[i] > mxy) mxy = shadow_y[i];
    end
    spx = (mxx == mnx) ? int'(ONE_Q4) : mxx - mnx;
    spy = (mxy == mny) ? int'(ONE_Q4) : mxy - mny;
    fan_queue.push_back(make_vertex(0, floor_half(mnx + mxx), floor_half(mny + mxy),
                                    mnx, mny, spx, spy, 1'b0));
    for (int i = 0; i < n; i++)
      fan_queue.push_back(make_vertex(i + 1, shadow_x[i], shadow_y[i],
                                      mnx, mny, spx, spy, 1'b0));
    fan_queue.push_back(make_vertex(n + 1, shadow_x[0], shadow_y[0],
                                    mnx, mny, spx, spy, 1'b1));
  endtask

  task automatic report(vertex_t want, vertex_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("vertex mismatch: expected slot %0d x %0d y %0d u %0d v %0d last %0b, got slot %0d x %0d y %0d u %0d v %0d last %0b",
               want.vertex_slot, want.pos_x, want.pos_y, want.tex_u, want.tex_v,
               want.last_of_run, got.vertex_slot, got.pos_x, got.pos_y, got.tex_u,
               got.tex_v, got.last_of_run);
  endtask

  // Result checker: every strobe is a transaction, compared field by field.
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && vertex_strobe) begin
      if (fan_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex slot %0d", vertex.vertex_slot);
      end else begin
        want = fan_queue.pop_front();
        if (want.vertex_slot !== vertex.vertex_slot || want.pos_x !== vertex.pos_x ||
            want.pos_y !== vertex.pos_y || want.tex_u !== vertex.tex_u ||
            want.tex_v !== vertex.tex_v || want.last_of_run !== vertex.last_of_run)
          report(want, vertex);
      end
    end
  end

  // Watchdog: cycles with no transaction on any side.
  always @(posedge clk) begin
    if (rst || vertex_strobe || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (!rst);
    wait (idle_cycles >= 20000);
    timed_out = 1'b1;
    $display("tb_convex_fan_vertex_setup_unit: errors");
    $finish;
  end

  task automatic send_item(item_t it);
    // Random gap before the item, skipped in the calm stretch.
    while (!calm && $urandom_range(99) < 37) @(posedge clk);
    start <= 1'b1;
    item  <= it;
    predict_fan(it);
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    item  <= item_t'($urandom);
    @(posedge clk);   // busy rises the cycle after acceptance
  endtask

  // Wait until every expected vertex is out, then let the block settle.
  task automatic drain;
    while (fan_queue.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_count(int value);
    while (!calm && $urandom_range(99) < 37) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= IDX_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fan_count = value;
  endtask

  function automatic item_t pick_item(int idx_hi);
    item_t it;
    it.point_index = IDX_W'($urandom_range(idx_hi));
    case ($urandom_range(5))
      0: begin it.point_x = 16'sh7fff; it.point_y = 16'sh8000; end
      1: begin it.point_x = COORD_W'($urandom_range(3)); it.point_y = 16'sd0; end
      default: begin it.point_x = COORD_W'($urandom); it.point_y = COORD_W'($urandom); end
    endcase
    return it;
  endfunction

  function automatic row_t mk_row(int idx, int x, int y);
    row_t r;
    r.it.point_index = IDX_W'(idx);
    r.it.point_x = COORD_W'(x);
    r.it.point_y = COORD_W'(y);
    r.has_hand = 1'b0;
    r.hand = '0;
    return r;
  endfunction

  initial begin
    row_t  r;
    int    counts[$];
    int    sent;
    rst = 1'b1; start = 1'b0; item = '0; cfg_valid = 1'b0; cfg_data = '0;
    mismatches = 0; idle_cycles = 0; timed_out = 1'b0; calm = 1'b0; fan_count = 0;
    foreach (shadow_x[i]) begin shadow_x[i] = 0; shadow_y[i] = 0; end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Count zero after reset: writes produce no fan.
    send_item(mk_row(0, 100, -100).it);
    send_item(mk_row(63, -1, 1).it);
    drain();

    // Three points: first row's centre is easy to read off a fresh store.
    write_count(3);
    r = mk_row(0, 32, 16);   // store (32,16),(0,0),(0,0)
    r.has_hand = 1'b1;
    r.hand.vertex_slot = '0; r.hand.pos_x = 16'sd16; r.hand.pos_y = 16'sd8;
    r.hand.tex_u = 17'h08000; r.hand.tex_v = 17'h08000; r.hand.last_of_run = 1'b0;
    rows.push_back(r);
    rows.push_back(mk_row(1, 32767, -32768));
    rows.push_back(mk_row(2, -32768, 32767));
    rows.push_back(mk_row(62, 5, 5));       // index out of range
    rows.push_back(mk_row(63, 0, 0));
    rows.push_back(mk_row(0, -3, 0));       // odd sum centre
    rows.push_back(mk_row(1, 0, 0));
    rows.push_back(mk_row(2, 0, 0));        // flat y axis
    rows.push_back(mk_row(0, 7, 7));
    rows.push_back(mk_row(1, 7, 7));
    rows.push_back(mk_row(2, 7, 7));        // both axes flat
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].has_hand) begin
        // Hand value sits at the head of the queue just queued.
        if (fan_queue[0] !== rows[i].hand) report(rows[i].hand, fan_queue[0]);
      end
    end
    drain();

    // Count above the store size acts as the full store.
    write_count(63);
    send_item(mk_row(61, -32768, -32768).it);
    send_item(mk_row(5, 32767, 32767).it);
    drain();
    write_count(62);
    send_item(mk_row(60, 1, -1).it);
    drain();

    // Random phases; mostly small fans, a few full-size.
    counts = '{3, 4, 2, 5, 1, 8, 3, 0, 6, 62, 4, 63};
    sent = 0;
    foreach (counts[c]) begin
      write_count(counts[c]);
      calm = (c == 4);
      for (int k = 0; k < ((counts[c] >= 62) ? 8 : 40); k++) begin
        send_item(pick_item((counts[c] >= 62) ? 63 : ((counts[c] < 3) ? 63 : counts[c] + 1)));
        sent++;
      end
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && fan_queue.size() == 0)
      $display("tb_convex_fan_vertex_setup_unit: clean");
    else
      $display("tb_convex_fan_vertex_setup_unit: errors");
    $finish;
  end

endmodule

`default_nettype wire
